@@ src/mtp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtp_pkg
// shared types and constants for the median time past tracker
// ----------------------------------------------------------------------------
package mtp_pkg;

   localparam int unsigned LIMIT_W = 16;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd11;

   typedef struct packed {
      logic [31:0]        timestamp;
      logic [31:0]        block_height;
      logic signed [31:0] header_version;
   } req_type;

   typedef struct packed {
      logic        applied;
      logic [31:0] tip_height;
      logic [31:0] median_time;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic update;
      logic scan_step;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic hit;
      logic last;
   } status_type;

endpackage
`default_nettype wire

@@ src/mtp_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtp_ctrl
// sequencer: takes a beat, updates history, scans for the median, emits
// ----------------------------------------------------------------------------
module mtp_ctrl
   import mtp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output cmd_type         cmd,
   input  wire status_type status
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_UPDATE,
      S_SCAN,
      S_DONE
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd.load      = (state_ff == S_IDLE) && req_valid && req_ready_ff;
      cmd.update    = (state_ff == S_UPDATE);
      cmd.scan_step = (state_ff == S_SCAN) && !status.empty;
      cmd.emit      = (state_ff == S_DONE) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && !cmd.emit) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready_ff) begin
                  req_ready_ff <= 1'b0;
                  state_ff     <= S_UPDATE;
               end
            end
            S_UPDATE: begin
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               if (status.empty || status.hit || status.last) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  req_ready_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

@@ src/mtp_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtp_datapath
// timestamp ring, count, tip height and rank-based upper median search
// ----------------------------------------------------------------------------
module mtp_datapath
   import mtp_pkg::*;
#(
   parameter int unsigned WINDOW = 11
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [LIMIT_W-1:0] csr_wdata,
   input  wire req_type            req_data,
   output rsp_type                 rsp_data,
   input  wire cmd_type            cmd,
   output status_type              status
);

   localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
   localparam int unsigned GAP_W  = SLOT_W + 2;

   logic [31:0]        window_ff [WINDOW];
   req_type            hdr_ff;
   rsp_type            rsp_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   cnt_in;
   logic [SLOT_W-1:0]  slot_ff;
   logic [SLOT_W-1:0]  slot_in;
   logic [SLOT_W-1:0]  cand_ff;
   logic [31:0]        tip_ff;
   logic [31:0]        median_ff;
   logic               applied_ff;
   logic               hdr_ok;
   logic [CNT_W-1:0]   lim_eff;
   logic [CNT_W:0]     cnt_inc;
   logic [WINDOW-1:0]  in_window;
   logic [CNT_W-1:0]   lt_cnt;
   logic [CNT_W-1:0]   le_cnt;
   logic [CNT_W-1:0]   mid;
   logic [31:0]        cand_val;

   assign hdr_ok  = hdr_ff.header_version > 32'sd0;
   assign lim_eff = (limit_ff < LIMIT_W'(WINDOW)) ? limit_ff[CNT_W-1:0] : CNT_W'(WINDOW);
   assign cnt_inc = {1'b0, cnt_ff} + {{CNT_W{1'b0}}, 1'b1};
   assign cnt_in  = (cnt_inc > {1'b0, lim_eff}) ? lim_eff : cnt_inc[CNT_W-1:0];
   assign slot_in = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;

   // entries among the newest cnt_ff slots, walking back from slot_ff
   always_comb begin
      logic [GAP_W-1:0] gap;
      for (int j = 0; j < WINDOW; j++) begin
         if (slot_ff >= SLOT_W'(j)) begin
            gap = GAP_W'(slot_ff) - GAP_W'(j);
         end else begin
            gap = GAP_W'(slot_ff) + GAP_W'(WINDOW) - GAP_W'(j);
         end
         in_window[j] = gap < GAP_W'(cnt_ff);
      end
   end

   assign cand_val = window_ff[cand_ff];
   assign mid      = cnt_ff >> 1;

   // rank of the candidate among the live entries
   always_comb begin
      lt_cnt = '0;
      le_cnt = '0;
      for (int j = 0; j < WINDOW; j++) begin
         lt_cnt = lt_cnt + CNT_W'(in_window[j] && (window_ff[j] < cand_val));
         le_cnt = le_cnt + CNT_W'(in_window[j] && (window_ff[j] <= cand_val));
      end
   end

   always_comb begin
      status.empty = (cnt_ff == '0);
      status.hit   = in_window[cand_ff] && (lt_cnt <= mid) && (mid < le_cnt);
      status.last  = (cand_ff == SLOT_W'(WINDOW - 1));
   end

   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff   <= LIMIT_RESET;
         cnt_ff     <= '0;
         slot_ff    <= '0;
         cand_ff    <= '0;
         tip_ff     <= '0;
         median_ff  <= '0;
         applied_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
         if (cmd.update) begin
            applied_ff <= hdr_ok;
            cand_ff    <= '0;
            if (hdr_ok) begin
               slot_ff <= slot_in;
               cnt_ff  <= cnt_in;
               if (cnt_in != '0) begin
                  tip_ff <= hdr_ff.block_height;
               end
            end
         end
         if (cmd.scan_step) begin
            if (status.hit) begin
               median_ff <= cand_val;
            end
            if (!status.last) begin
               cand_ff <= cand_ff + 1'b1;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         hdr_ff <= req_data;
      end
      if (cmd.update && hdr_ok) begin
         window_ff[slot_in] <= hdr_ff.timestamp;
      end
      if (cmd.emit) begin
         rsp_ff.applied     <= applied_ff;
         rsp_ff.tip_height  <= tip_ff;
         rsp_ff.median_time <= median_ff;
      end
   end

endmodule
`default_nettype wire

@@ src/median_time_past_tracker_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// median_time_past_tracker_top
// header history tracker reporting tip height and upper median time past
// ----------------------------------------------------------------------------
// each beat passes through the update and scan states before its result is emitted;
// no new beat is taken until the result is emitted; the rank scan tests one stored
//   timestamp per cycle against all live entries
// a finished result waits in the output register while the next beat is taken
// reset: synchronous; history empty, tip and median zero, limit 11
module median_time_past_tracker_top
   import mtp_pkg::*;
#(
   parameter int unsigned WINDOW = 11
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire req_type            req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output rsp_type                 rsp_data,
   input  wire logic               csr_we,
   input  wire logic [LIMIT_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   mtp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   mtp_datapath #(
      .WINDOW (WINDOW)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

   a_load_then_update: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.update)
      else $error("load not followed by update");

   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready while beat in flight");

   a_hit_needs_history: assert property (@(posedge clock) disable iff (reset)
      status.hit |-> !status.empty)
      else $error("median hit with empty history");

   a_emit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid)
      else $error("emitted result not presented");

endmodule
`default_nettype wire
